// ----- src/ihc_pkg.sv -----
// ihc_pkg: shared constants and helpers for the ipv4 header checker
package ihc_pkg;

  localparam int LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [5:0] MIN_HDR = 6'd20;
  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [15:0] SUM_GOOD = 16'hFFFF;

  localparam logic [LENGTH_BITS-1:0] OFS_VER_IHL = LENGTH_BITS'(0);
  localparam logic [LENGTH_BITS-1:0] OFS_TLEN_HI = LENGTH_BITS'(2);
  localparam logic [LENGTH_BITS-1:0] OFS_TLEN_LO = LENGTH_BITS'(3);
  localparam logic [LENGTH_BITS-1:0] OFS_PROTO = LENGTH_BITS'(9);
  localparam logic [LENGTH_BITS-1:0] OFS_SRC_FIRST = LENGTH_BITS'(12);
  localparam logic [LENGTH_BITS-1:0] OFS_SRC_LAST = LENGTH_BITS'(15);
  localparam logic [LENGTH_BITS-1:0] OFS_DST_FIRST = LENGTH_BITS'(16);
  localparam logic [LENGTH_BITS-1:0] OFS_DST_LAST = LENGTH_BITS'(19);

  typedef logic [LENGTH_BITS-1:0] count_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- src/ihc_if.sv -----
// ihc_if: valid/ready byte and result channels of the ipv4 header checker
interface ihc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source(output valid, output data_byte, output end_of_packet, input ready);
  modport sink(input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface ihc_out_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic [7:0]  protocol;
  logic [5:0]  header_bytes;
  logic [15:0] payload_bytes;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;

  modport source(output valid, output header_ok, output protocol, output header_bytes,
                 output payload_bytes, output source_addr, output dest_addr, input ready);
  modport sink(input valid, input header_ok, input protocol, input header_bytes,
               input payload_bytes, input source_addr, input dest_addr, output ready);
endinterface

// ----- src/ipv4_header_checker_unit.sv -----
// ipv4_header_checker_unit: byte-stream ipv4 header validation, top level
// Takes one packet byte per beat, with end_of_packet on the final byte, and
// gives one result beat per packet once its final byte has passed the input
// and result registers. A new byte is taken every cycle: bytes pass an
// input register, the capture and checksum logic, and a result register,
// so the only stall is a final byte meeting a result not yet taken.
// The byte count saturates at 65535; from then on bytes are counted and
// captured no further. payload_bytes reads zero when header_ok is low.
module ipv4_header_checker_unit (
  input logic     clk,
  input logic     rst_n,
  ihc_in_if.sink  in_ch,
  ihc_out_if.source out_ch
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eop_r;
  logic        s1_adv;

  ihc_pkg::count_t cnt_r, cnt_nxt;
  logic [7:0]  vihl_r, vihl_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  hi_r, hi_nxt;

  logic [5:0]  hl;
  logic        ok;

  logic        out_valid_r;
  logic        ok_r;
  logic [7:0]  proto_out_r;
  logic [5:0]  hl_r;
  logic [15:0] pay_r;
  logic [31:0] src_out_r;
  logic [31:0] dst_out_r;

  assign s1_adv = s1_valid_r && (!s1_eop_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_eop_r  <= in_ch.end_of_packet;
    end
  end

  // capture and checksum
  always_comb begin
    cnt_nxt   = cnt_r;
    vihl_nxt  = vihl_r;
    tlen_nxt  = tlen_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    if (cnt_r != ihc_pkg::COUNT_MAX) begin
      priority if (cnt_r == ihc_pkg::OFS_VER_IHL) begin
        vihl_nxt = s1_byte_r;
      end else if (cnt_r == ihc_pkg::OFS_TLEN_HI || cnt_r == ihc_pkg::OFS_TLEN_LO) begin
        tlen_nxt = {tlen_r[7:0], s1_byte_r};
      end else if (cnt_r == ihc_pkg::OFS_PROTO) begin
        proto_nxt = s1_byte_r;
      end else if (cnt_r >= ihc_pkg::OFS_SRC_FIRST && cnt_r <= ihc_pkg::OFS_SRC_LAST) begin
        src_nxt = {src_r[23:0], s1_byte_r};
      end else if (cnt_r >= ihc_pkg::OFS_DST_FIRST && cnt_r <= ihc_pkg::OFS_DST_LAST) begin
        dst_nxt = {dst_r[23:0], s1_byte_r};
      end else begin
        vihl_nxt = vihl_r;
      end
      if (17'(cnt_r) < 17'({vihl_nxt[3:0], 2'b00})) begin
        if (!cnt_r[0]) begin
          hi_nxt = s1_byte_r;
        end else begin
          sum_nxt = ihc_pkg::ones_add(sum_r, {hi_r, s1_byte_r});
        end
      end
      cnt_nxt = cnt_r + ihc_pkg::count_t'(1);
    end
  end

  assign hl = {vihl_nxt[3:0], 2'b00};
  assign ok = (17'(cnt_nxt) >= 17'(ihc_pkg::MIN_HDR))
           && (vihl_nxt[7:4] == ihc_pkg::IP_VERSION)
           && (hl >= ihc_pkg::MIN_HDR)
           && (17'(hl) <= 17'(cnt_nxt))
           && (tlen_nxt >= 16'(hl))
           && (17'(tlen_nxt) <= 17'(cnt_nxt))
           && (sum_nxt == ihc_pkg::SUM_GOOD);

  // packet state, cleared after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_eop_r)) begin
      cnt_r   <= '0;
      vihl_r  <= '0;
      tlen_r  <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      sum_r   <= '0;
      hi_r    <= '0;
    end else if (s1_adv) begin
      cnt_r   <= cnt_nxt;
      vihl_r  <= vihl_nxt;
      tlen_r  <= tlen_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      sum_r   <= sum_nxt;
      hi_r    <= hi_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_eop_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_eop_r) begin
      ok_r        <= ok;
      proto_out_r <= proto_nxt;
      hl_r        <= hl;
      pay_r       <= ok ? (tlen_nxt - 16'(hl)) : 16'd0;
      src_out_r   <= src_nxt;
      dst_out_r   <= dst_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.header_ok     = ok_r;
  assign out_ch.protocol      = proto_out_r;
  assign out_ch.header_bytes  = hl_r;
  assign out_ch.payload_bytes = pay_r;
  assign out_ch.source_addr   = src_out_r;
  assign out_ch.dest_addr     = dst_out_r;

  a_clear_after_eop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_eop_r |=> cnt_r == '0 && sum_r == '0)
    else $error("packet state not cleared after final byte");

  a_ok_min_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ok_r |-> hl_r >= ihc_pkg::MIN_HDR)
    else $error("valid header shorter than minimum");

  a_bad_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !ok_r |-> pay_r == 16'd0)
    else $error("payload length given for invalid header");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !(s1_adv && s1_eop_r))
    else $error("result overwritten before it was taken");

endmodule
